### rtl/cpt_pkg.sv
// Shared types and constants for the cyclotron transverse momentum unit.
// No dependencies; every other file but cpt_checker imports this package.
package cpt_pkg;

	localparam int TOF_W     = 24;
	localparam int PERIOD_W  = 24;
	localparam int POS_W     = 20;
	localparam int PHASE_W   = 32;
	localparam int MOM_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 24;
	localparam int CS_W      = 33;
	localparam int ANG_W     = 33;
	localparam int ATAN_W    = 30;
	localparam int OMC_W     = 34;
	localparam int NUM_W     = 55;
	localparam int DIV_W     = 58;
	localparam int GAIN_W    = 28;

	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCKWISE = 2'd1;

	localparam logic [PERIOD_W-1:0]   PERIOD_RST    = 24'd2048;
	localparam logic                  CLOCKWISE_RST = 1'b1;
	localparam logic signed [CS_W-1:0] CORDIC_X0    = 33'sd652032874;
	localparam logic [GAIN_W-1:0]     GAIN_Q16      = 28'd192556892;

	// arctan(2^-i) in units of 2^-32 turn
	localparam logic [ATAN_W-1:0] ATAN_TURNS [32] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81,
		30'd41,        30'd20,        30'd10,        30'd5,
		30'd3,         30'd1,         30'd1,         30'd0
	};

	typedef enum logic [1:0] {
		QUAD_0,
		QUAD_90,
		QUAD_180,
		QUAD_270
	} cpt_quad_t;

	typedef struct packed {
		logic                    vld;
		logic signed [POS_W-1:0] hx;
		logic signed [POS_W-1:0] hy;
	} cpt_hit_t;

	typedef struct packed {
		logic vld;
		logic void_res;
	} cpt_ctl_t;

endpackage

### rtl/cpt_phase_div.sv
// Pipelined restoring divider: phase = floor((tof mod T) * 2^32 / T).
// Depends on cpt_pkg.
module cpt_phase_div import cpt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cpt_hit_t            hit_in,
	input  logic [TOF_W-1:0]    tof,
	input  logic [PERIOD_W-1:0] period,
	output cpt_hit_t            hit_out,
	output logic [PHASE_W-1:0]  phase
);

	localparam int STEPS = TOF_W + PHASE_W;

	cpt_hit_t            hit_s [0:STEPS];
	logic [TOF_W-1:0]    tof_s [0:TOF_W-1];
	logic [PERIOD_W-1:0] rem_s [0:STEPS];
	logic [PHASE_W-1:0]  quo_s [0:STEPS];

	assign hit_s[0] = hit_in;
	assign tof_s[0] = tof;
	assign rem_s[0] = '0;
	assign quo_s[0] = '0;

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic              bit_in;
		logic [PERIOD_W:0] trial;
		logic              take;

		if (k < TOF_W) begin : g_num
			assign bit_in = tof_s[k][TOF_W-1-k];
			if (k + 1 < TOF_W) begin : g_carry
				always_ff @(posedge clk) begin
					tof_s[k+1] <= tof_s[k];
				end
			end
		end else begin : g_pad
			assign bit_in = 1'b0;
		end

		assign trial = {rem_s[k], bit_in};
		assign take  = trial >= {1'b0, period};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hit_s[k+1] <= '0;
			end else begin
				hit_s[k+1] <= hit_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? PERIOD_W'(trial - {1'b0, period}) : trial[PERIOD_W-1:0];
			quo_s[k+1] <= {quo_s[k][PHASE_W-2:0], take};
		end
	end

	assign hit_out = hit_s[STEPS];
	assign phase   = quo_s[STEPS];

endmodule

### rtl/cpt_cordic.sv
// Pipelined rotation CORDIC: sine and cosine (Q30) of a phase in turns.
// Depends on cpt_pkg.
module cpt_cordic import cpt_pkg::*; #(
	parameter int STAGES = 20
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cpt_hit_t               hit_in,
	input  logic [PHASE_W-1:0]     phase,
	input  logic                   clockwise,
	output cpt_hit_t               hit_out,
	output logic signed [CS_W-1:0] cos_o,
	output logic signed [CS_W-1:0] sin_o
);

	localparam logic [PHASE_W-1:0]     EIGHTH = PHASE_W'(32'h2000_0000);
	localparam logic signed [ANG_W-1:0] R_OFS = 33'sd536870912;

	logic [PHASE_W-1:0] ph_dir;
	logic [PHASE_W-1:0] z;

	cpt_hit_t               hit_c  [0:STAGES];
	cpt_quad_t              quad_c [0:STAGES];
	logic signed [ANG_W-1:0] r_c   [0:STAGES-1];
	logic signed [CS_W-1:0] cx_c   [0:STAGES];
	logic signed [CS_W-1:0] cy_c   [0:STAGES];

	assign ph_dir = clockwise ? PHASE_W'(0) - phase : phase;
	assign z      = ph_dir + EIGHTH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_c[0] <= '0;
		end else begin
			hit_c[0] <= hit_in;
		end
	end

	always_ff @(posedge clk) begin
		quad_c[0] <= cpt_quad_t'(z[PHASE_W-1:PHASE_W-2]);
		r_c[0]    <= $signed({3'b000, z[PHASE_W-3:0]}) - R_OFS;
	end

	assign cx_c[0] = CORDIC_X0;
	assign cy_c[0] = '0;

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		logic signed [CS_W-1:0] dx;
		logic signed [CS_W-1:0] dy;
		logic                   up;

		assign dx = cy_c[i] >>> i;
		assign dy = cx_c[i] >>> i;
		assign up = !r_c[i][ANG_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hit_c[i+1] <= '0;
			end else begin
				hit_c[i+1] <= hit_c[i];
			end
		end

		always_ff @(posedge clk) begin
			quad_c[i+1] <= quad_c[i];
			cx_c[i+1]   <= up ? cx_c[i] - dx : cx_c[i] + dx;
			cy_c[i+1]   <= up ? cy_c[i] + dy : cy_c[i] - dy;
		end

		if (i + 1 < STAGES) begin : g_ang
			always_ff @(posedge clk) begin
				r_c[i+1] <= up ? r_c[i] - $signed({3'b000, ATAN_TURNS[i]})
				               : r_c[i] + $signed({3'b000, ATAN_TURNS[i]});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_out <= '0;
		end else begin
			hit_out <= hit_c[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		unique case (quad_c[STAGES])
			QUAD_0: begin
				cos_o <= cx_c[STAGES];
				sin_o <= cy_c[STAGES];
			end
			QUAD_90: begin
				cos_o <= -cy_c[STAGES];
				sin_o <= cx_c[STAGES];
			end
			QUAD_180: begin
				cos_o <= -cx_c[STAGES];
				sin_o <= -cy_c[STAGES];
			end
			default: begin
				cos_o <= cy_c[STAGES];
				sin_o <= -cx_c[STAGES];
			end
		endcase
	end

endmodule

### rtl/cpt_numer.sv
// Numerators of both momenta and the shared divisor T * (2 - 2cos).
// Depends on cpt_pkg.
module cpt_numer import cpt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cpt_hit_t                hit_in,
	input  logic signed [CS_W-1:0]  cos_i,
	input  logic signed [CS_W-1:0]  sin_i,
	input  logic [PERIOD_W-1:0]     period,
	output cpt_ctl_t                ctl_out,
	output logic signed [NUM_W-1:0] num_x,
	output logic signed [NUM_W-1:0] num_y,
	output logic [DIV_W-1:0]        dd
);

	localparam logic signed [OMC_W-1:0] Q30_ONE = 34'sd1073741824;

	logic                    vld_s1;
	logic signed [OMC_W-1:0] omc_s1;
	logic signed [CS_W-1:0]  sin_s1;
	logic signed [POS_W-1:0] hx_s1;
	logic signed [POS_W-1:0] hy_s1;

	cpt_ctl_t                        ctl_s2;
	logic signed [POS_W+CS_W-1:0]    hxs_s2;
	logic signed [POS_W+CS_W-1:0]    hys_s2;
	logic signed [POS_W+OMC_W-1:0]   hxo_s2;
	logic signed [POS_W+OMC_W-1:0]   hyo_s2;
	logic [DIV_W-1:0]                dd_s2;
	logic [OMC_W-1:0]                den;

	assign den = {omc_s1[OMC_W-2:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			ctl_s2  <= '0;
			ctl_out <= '0;
		end else begin
			vld_s1           <= hit_in.vld;
			ctl_s2.vld       <= vld_s1;
			ctl_s2.void_res  <= (omc_s1 <= 0) || (period == '0);
			ctl_out          <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		omc_s1 <= Q30_ONE - OMC_W'(cos_i);
		sin_s1 <= sin_i;
		hx_s1  <= hit_in.hx;
		hy_s1  <= hit_in.hy;

		hxs_s2 <= hx_s1 * sin_s1;
		hys_s2 <= hy_s1 * sin_s1;
		hxo_s2 <= hx_s1 * omc_s1;
		hyo_s2 <= hy_s1 * omc_s1;
		dd_s2  <= period * den;

		num_x <= NUM_W'(hxs_s2) - NUM_W'(hyo_s2);
		num_y <= -NUM_W'(hxo_s2) - NUM_W'(hys_s2);
		dd    <= dd_s2;
	end

endmodule

### rtl/cpt_scale_div.sv
// Scales one numerator by the gain and divides by T * den with rounding,
// clipping and sign; pipelined restoring divider. Depends on cpt_pkg.
module cpt_scale_div import cpt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cpt_ctl_t                ctl_in,
	input  logic signed [NUM_W-1:0] num,
	input  logic [DIV_W-1:0]        dd,
	input  logic                    clockwise,
	output logic                    vld,
	output logic [MOM_W-1:0]        momentum,
	output logic                    sat
);

	localparam int MAG_W  = NUM_W - 1;
	localparam int HALF_W = MAG_W / 2;
	localparam int HI_W   = MAG_W - HALF_W;
	localparam int PP_W   = HI_W + GAIN_W;
	localparam int PROD_W = PP_W + HALF_W;
	localparam int QB     = 33;
	localparam int Q_W    = QB + 1;
	localparam logic [Q_W-1:0] LIM_POS = Q_W'(34'h0_7FFF_FFFF);
	localparam logic [Q_W-1:0] LIM_NEG = Q_W'(34'h0_8000_0000);

	cpt_ctl_t              ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic                  neg_s1, neg_s2, neg_s3, neg_s4;
	logic [DIV_W-1:0]      dd_s1, dd_s2, dd_s3, dd_s4;
	logic [MAG_W-1:0]      mag_s1;
	logic [HALF_W+GAIN_W-1:0] plo_s2;
	logic [PP_W-1:0]       phi_s2;
	logic [PROD_W-1:0]     prod_s3;
	logic                  big_s4;

	cpt_ctl_t         ctl_d [0:QB];
	logic             neg_d [0:QB];
	logic             big_d [0:QB];
	logic [DIV_W-1:0] dd_d  [0:QB];
	logic [DIV_W-1:0] rem_d [0:QB];
	logic [QB-1:0]    low_d [0:QB];
	logic [QB-1:0]    quo_d [0:QB];

	cpt_ctl_t         ctl_r1, ctl_r2;
	logic             neg_r1, neg_r2;
	logic             big_r1, big_r2;
	logic             rnd_r1;
	logic [QB-1:0]    quo_r1;
	logic [Q_W-1:0]   q_r2;

	logic [Q_W-1:0]   limit;
	logic             clip;
	logic [Q_W-1:0]   val;
	logic [MOM_W-1:0] signed_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= num[NUM_W-1] ^ clockwise;
		mag_s1 <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
		dd_s1  <= dd;

		neg_s2 <= neg_s1;
		dd_s2  <= dd_s1;
		plo_s2 <= mag_s1[HALF_W-1:0] * GAIN_Q16;
		phi_s2 <= mag_s1[MAG_W-1:HALF_W] * GAIN_Q16;

		neg_s3  <= neg_s2;
		dd_s3   <= dd_s2;
		prod_s3 <= PROD_W'(plo_s2) + {phi_s2, {HALF_W{1'b0}}};

		neg_s4 <= neg_s3;
		dd_s4  <= dd_s3;
		big_s4 <= DIV_W'(prod_s3[PROD_W-1:QB]) >= dd_s3;
		rem_d[0] <= DIV_W'(prod_s3[PROD_W-1:QB]);
		low_d[0] <= prod_s3[QB-1:0];
	end

	assign ctl_d[0] = ctl_s4;
	assign neg_d[0] = neg_s4;
	assign big_d[0] = big_s4;
	assign dd_d[0]  = dd_s4;
	assign quo_d[0] = '0;

	for (genvar k = 0; k < QB; k++) begin : g_step
		logic [DIV_W:0] trial;
		logic           take;

		assign trial = {rem_d[k], low_d[k][QB-1-k]};
		assign take  = trial >= {1'b0, dd_d[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_d[k+1] <= '0;
			end else begin
				ctl_d[k+1] <= ctl_d[k];
			end
		end

		always_ff @(posedge clk) begin
			neg_d[k+1] <= neg_d[k];
			big_d[k+1] <= big_d[k];
			dd_d[k+1]  <= dd_d[k];
			low_d[k+1] <= low_d[k];
			rem_d[k+1] <= take ? DIV_W'(trial - {1'b0, dd_d[k]}) : trial[DIV_W-1:0];
			quo_d[k+1] <= {quo_d[k][QB-2:0], take};
		end
	end

	assign limit      = neg_r2 ? LIM_NEG : LIM_POS;
	assign clip       = big_r2 || (q_r2 > limit);
	assign val        = clip ? limit : q_r2;
	assign signed_val = neg_r2 ? MOM_W'(0) - val[MOM_W-1:0] : val[MOM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_r1 <= '0;
			ctl_r2 <= '0;
			vld    <= 1'b0;
		end else begin
			ctl_r1 <= ctl_d[QB];
			ctl_r2 <= ctl_r1;
			vld    <= ctl_r2.vld;
		end
	end

	always_ff @(posedge clk) begin
		neg_r1 <= neg_d[QB];
		big_r1 <= big_d[QB];
		quo_r1 <= quo_d[QB];
		rnd_r1 <= {rem_d[QB], 1'b0} >= {1'b0, dd_d[QB]};

		neg_r2 <= neg_r1;
		big_r2 <= big_r1;
		q_r2   <= Q_W'(quo_r1) + Q_W'(rnd_r1);

		momentum <= ctl_r2.void_res ? '0 : signed_val;
		sat      <= ctl_r2.void_res || clip;
	end

endmodule

### rtl/cyclotron_transverse_momentum_unit.sv
// Top level of the cyclotron transverse momentum unit.
// Depends on cpt_pkg, cpt_phase_div, cpt_cordic, cpt_numer and cpt_scale_div.
//
// Takes one hit per clock (busy is always low) and returns its results in
// order, one done pulse per hit. The pipeline holds the 56-step phase
// divider, the CORDIC chain of CORDIC_STAGES rotations and the 33-step
// quotient divider, each one step per register stage. Results cannot be
// held off; the receiver must take them on the done cycle. Write the period
// and direction registers only while no hit is in flight.
module cyclotron_transverse_momentum_unit import cpt_pkg::*; #(
	parameter int CORDIC_STAGES = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [TOF_W-1:0]        flight_time,
	input  logic signed [POS_W-1:0] hit_x,
	input  logic signed [POS_W-1:0] hit_y,
	output logic                    done,
	output logic signed [MOM_W-1:0] momentum_x,
	output logic signed [MOM_W-1:0] momentum_y,
	output logic                    saturated,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DAT_W-1:0]    cfg_data
);

	localparam int LATENCY = 102 + CORDIC_STAGES;

	logic [PERIOD_W-1:0] period_q;
	logic                clockwise_q;

	cpt_hit_t               hit_in, hit_ph, hit_cs;
	logic [PHASE_W-1:0]     phase;
	logic signed [CS_W-1:0] cos_v, sin_v;
	cpt_ctl_t               ctl_n;
	logic signed [NUM_W-1:0] num_x, num_y;
	logic [DIV_W-1:0]       dd;
	logic                   vld_x, vld_y, sat_x, sat_y;
	logic [MOM_W-1:0]       mom_x, mom_y;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PERIOD_RST;
			clockwise_q <= CLOCKWISE_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_PERIOD) begin
				period_q <= cfg_data[PERIOD_W-1:0];
			end
			if (cfg_index == CFG_CLOCKWISE) begin
				clockwise_q <= cfg_data[0];
			end
		end
	end

	assign hit_in.vld = start && !busy;
	assign hit_in.hx  = hit_x;
	assign hit_in.hy  = hit_y;

	cpt_phase_div u_phase (
		.clk     (clk),
		.arst_n  (arst_n),
		.hit_in  (hit_in),
		.tof     (flight_time),
		.period  (period_q),
		.hit_out (hit_ph),
		.phase   (phase)
	);

	cpt_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.hit_in    (hit_ph),
		.phase     (phase),
		.clockwise (clockwise_q),
		.hit_out   (hit_cs),
		.cos_o     (cos_v),
		.sin_o     (sin_v)
	);

	cpt_numer u_numer (
		.clk     (clk),
		.arst_n  (arst_n),
		.hit_in  (hit_cs),
		.cos_i   (cos_v),
		.sin_i   (sin_v),
		.period  (period_q),
		.ctl_out (ctl_n),
		.num_x   (num_x),
		.num_y   (num_y),
		.dd      (dd)
	);

	cpt_scale_div u_div_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_n),
		.num       (num_x),
		.dd        (dd),
		.clockwise (clockwise_q),
		.vld       (vld_x),
		.momentum  (mom_x),
		.sat       (sat_x)
	);

	cpt_scale_div u_div_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_n),
		.num       (num_y),
		.dd        (dd),
		.clockwise (clockwise_q),
		.vld       (vld_y),
		.momentum  (mom_y),
		.sat       (sat_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_x && vld_y;
		end
	end

	always_ff @(posedge clk) begin
		momentum_x <= mom_x;
		momentum_y <= mom_y;
		saturated  <= sat_x || sat_y;
	end

endmodule

### rtl/cpt_checker.sv
// Port-level checks for the cyclotron transverse momentum unit, bound to the top.
// Depends on cyclotron_transverse_momentum_unit.
module cpt_checker #(
	parameter int LATENCY = 122
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_valid,
	input logic cfg_ready
);

	a_done_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a transaction accepted at the pipeline latency");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("input transaction refused");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration transaction refused");

endmodule

bind cyclotron_transverse_momentum_unit cpt_checker #(
	.LATENCY (LATENCY)
) u_cpt_checker (.*);
